@@ src/ascii85_stream_encoder_unit_macros.svh @@
// assertion macros for the ascii85 stream encoder
`ifndef ASCII85_STREAM_ENCODER_UNIT_MACROS_SVH
`define ASCII85_STREAM_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define A85ENC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define A85ENC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/a85enc_pkg.sv @@
// shared types and constants for the ascii85 stream encoder
`default_nettype none

package a85enc_pkg;

	localparam int unsigned JQ_DEPTH_DEF = 4;
	localparam int unsigned GROUP_CHARS  = 5;
	localparam int unsigned QUOT_W       = 26;
	localparam int unsigned RECIP_SHIFT  = 38;

	localparam logic [6:0]  RADIX        = 7'd85;
	localparam logic [6:0]  DIGIT_BASE   = 7'd33;
	localparam logic [6:0]  ZERO_CHAR    = 7'h7A;
	// ceil(2^38 / 85), exact quotient for every 32-bit dividend
	localparam logic [31:0] RECIP_MAGIC  = 32'hC0C0C0C1;

	typedef logic [6:0] digit_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nchars;
		logic        zero;
		logic        last;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} jq_status_t;

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN  = 3'b010,
		C_HOLD = 3'b100
	} conv_state_t;

endpackage

`default_nettype wire

@@ src/a85enc_front.sv @@
// front end: packs bytes into groups and classifies each finished group
`default_nettype none

module a85enc_front import a85enc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	input  jq_status_t jq_stat,
	output logic       full,
	output logic       job_wr,
	output job_t       job
);

	logic [31:0] group_q;
	logic [1:0]  pos_q;
	logic [31:0] word_nx;
	logic        take;
	logic        flush;
	logic        grp_full;

	always_comb begin
		word_nx = group_q;
		case (pos_q)
			2'd0: begin
				word_nx[31:24] = data_byte;
			end
			2'd1: begin
				word_nx[23:16] = data_byte;
			end
			2'd2: begin
				word_nx[15:8] = data_byte;
			end
			default: begin
				word_nx[7:0] = data_byte;
			end
		endcase
	end

	assign full     = jq_stat.full;
	assign take     = push & ~full;
	assign grp_full = (pos_q == 2'd3);
	assign flush    = grp_full | final_byte;
	assign job_wr   = take & flush;

	always_comb begin
		job.word = word_nx;
		job.last = final_byte;
		job.zero = grp_full & (word_nx == 32'd0);
		if (grp_full) begin
			job.nchars = job.zero ? 3'd1 : 3'(GROUP_CHARS);
		end else begin
			// partial final group keeps one char more than its byte count
			job.nchars = {1'b0, pos_q} + 3'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= 32'd0;
			pos_q   <= 2'd0;
		end else if (take) begin
			if (flush) begin
				group_q <= 32'd0;
				pos_q   <= 2'd0;
			end else begin
				group_q <= word_nx;
				pos_q   <= pos_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/a85enc_queue.sv @@
// short job queue between front end and back end
`default_nettype none

module a85enc_queue import a85enc_pkg::*; #(
	parameter int unsigned DEPTH = JQ_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  job_t       wr_job,
	input  logic       rd,
	output job_t       rd_job,
	output jq_status_t stat
);

	// depth is a power of two, 2 and up
	localparam int unsigned PW = $clog2(DEPTH);

	job_t        mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;
	logic          wr_en;
	logic          rd_en;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == (PW + 1)'(DEPTH));
	assign wr_en      = wr & ~stat.full;
	assign rd_en      = rd & ~stat.empty;
	assign rd_job     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/a85enc_back.sv @@
// back end: base-85 digit extraction and character output register
`default_nettype none

module a85enc_back import a85enc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  jq_status_t jq_stat,
	input  job_t       jq_job,
	output logic       jq_rd,
	input  logic       pop,
	output logic       empty,
	output logic [6:0] out_char,
	output logic       group_end,
	output logic       stream_end
);

	conv_state_t       cst_q;
	logic [1:0]        step_q;
	logic [31:0]       divd_q;
	logic [QUOT_W-1:0] quot_q;
	digit_t            dig_q [GROUP_CHARS];
	logic [2:0]        cn_q;
	logic              cz_q;
	logic              cl_q;

	logic              em_busy_q;
	logic [2:0]        em_idx_q;
	digit_t            em_dig_q [GROUP_CHARS];
	logic [2:0]        em_n_q;
	logic              em_zero_q;
	logic              em_last_q;

	logic              em_end;
	logic              em_free;
	logic              hand;
	logic              load;
	logic [31:0]       mul_a;
	logic [63:0]       mul_full;
	logic [QUOT_W-1:0] quot_nx;
	logic [31:0]       q_times_radix;
	logic [31:0]       rem_full;
	digit_t            rem;

	assign em_end  = (em_idx_q == em_n_q - 3'd1);
	assign em_free = ~em_busy_q | (pop & em_end);
	assign hand    = (cst_q == C_HOLD) & em_free;
	assign load    = ~jq_stat.empty & ((cst_q == C_IDLE) | hand);
	assign jq_rd   = load;

	// one shared reciprocal multiplier, fed by a new group or the last quotient
	assign mul_a    = load ? jq_job.word : 32'(quot_q);
	assign mul_full = 64'(mul_a) * 64'(RECIP_MAGIC);
	assign quot_nx  = mul_full[63:RECIP_SHIFT];

	assign q_times_radix = 32'(quot_q) * 32'(RADIX);
	assign rem_full      = divd_q - q_times_radix;
	assign rem           = rem_full[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q  <= C_IDLE;
			step_q <= 2'd0;
		end else begin
			case (cst_q)
				C_IDLE: begin
					if (load) begin
						cst_q <= C_RUN;
					end
				end
				C_RUN: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						cst_q <= C_HOLD;
					end
				end
				C_HOLD: begin
					if (hand) begin
						cst_q <= load ? C_RUN : C_IDLE;
					end
				end
				default: begin
					cst_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			divd_q <= jq_job.word;
			quot_q <= quot_nx;
			cn_q   <= jq_job.nchars;
			cz_q   <= jq_job.zero;
			cl_q   <= jq_job.last;
		end else if (cst_q == C_RUN) begin
			divd_q <= 32'(quot_q);
			quot_q <= quot_nx;
			// least significant digit first
			dig_q[3'(3'd4 - {1'b0, step_q})] <= rem;
			if (step_q == 2'd3) begin
				dig_q[0] <= quot_q[6:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_busy_q <= 1'b0;
			em_idx_q  <= 3'd0;
		end else if (hand) begin
			em_busy_q <= 1'b1;
			em_idx_q  <= 3'd0;
		end else if (pop && em_busy_q) begin
			if (em_end) begin
				em_busy_q <= 1'b0;
			end else begin
				em_idx_q <= em_idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hand) begin
			em_dig_q  <= dig_q;
			em_n_q    <= cn_q;
			em_zero_q <= cz_q;
			em_last_q <= cl_q;
		end
	end

	assign empty      = ~em_busy_q;
	assign out_char   = em_zero_q ? ZERO_CHAR : (em_dig_q[em_idx_q] + DIGIT_BASE);
	assign group_end  = em_end;
	assign stream_end = em_end & em_last_q;

endmodule

`default_nettype wire

@@ src/ascii85_stream_encoder_unit.sv @@
// ascii85 stream encoder: one byte per request in, one character per request out
// path: a closed group passes through the job queue, the digit unit and the output stage before its first char shows
// throughput: one byte per cycle in until the job queue fills, one character per cycle out while empty is low
// a group occupies the digit unit for a load plus four divide-by-85 steps, then holds until the output stage is free
// reset: arst_n clears the partial group, the queue and both back-end stages at once
`default_nettype none

module ascii85_stream_encoder_unit import a85enc_pkg::*; #(
	parameter int unsigned JQ_DEPTH = JQ_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       empty,
	input  logic       pop,
	output logic [6:0] out_char,
	output logic       group_end,
	output logic       stream_end
);

`include "ascii85_stream_encoder_unit_macros.svh"

	// front to queue: a finished group, tagged with how many chars it makes
	job_t       fq_job;
	logic       fq_wr;
	// queue to back end
	job_t       qb_job;
	logic       qb_rd;
	jq_status_t jq_stat;

	// byte packing; stalls only when the job queue is full
	a85enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.jq_stat    (jq_stat),
		.full       (full),
		.job_wr     (fq_wr),
		.job        (fq_job)
	);

	// decouples byte intake from the slower character output
	a85enc_queue #(
		.DEPTH (JQ_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fq_wr),
		.wr_job (fq_job),
		.rd     (qb_rd),
		.rd_job (qb_job),
		.stat   (jq_stat)
	);

	// digit extraction overlaps with output of the previous group
	a85enc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.jq_stat    (jq_stat),
		.jq_job     (qb_job),
		.jq_rd      (qb_rd),
		.pop        (pop),
		.empty      (empty),
		.out_char   (out_char),
		.group_end  (group_end),
		.stream_end (stream_end)
	);

	// the stream always ends on the last char of a group
	`A85ENC_ASSERT_IMPLY(a_stream_end_on_group_end, !empty && stream_end, group_end, "stream end without group end")
	// a zero group is a single 'z'
	`A85ENC_ASSERT_IMPLY(a_z_closes_group, !empty && out_char == ZERO_CHAR, group_end, "z not closing its group")
	// only base-85 digits or 'z' leave the block
	`A85ENC_ASSERT_IMPLY(a_char_range, !empty, (out_char >= DIGIT_BASE && out_char <= DIGIT_BASE + RADIX - 7'd1) || out_char == ZERO_CHAR, "character out of range")
	// the rest of a group follows without a gap
	`A85ENC_ASSERT_NEXT(a_group_contiguous, !empty && pop && !group_end, !empty, "gap inside a group")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// self-checking testbench for the ascii85 stream encoder unit
`default_nettype none

module tb;
	import a85enc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// no request taken on either side for this many cycles ends the run
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// settle time after the last character: queue, digit unit and output stage
	localparam int unsigned TAIL_CYCLES = 40;
	// long receiver hold-off used to back the job queue up into the input
	localparam int unsigned HOLD_OFF_CYCLES = 300;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] data_byte = 8'h00;
	logic       final_byte = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [6:0] out_char;
	logic       group_end;
	logic       stream_end;

	// one encoded character as it should leave the block
	typedef struct packed {
		logic [6:0] ch;
		logic       grp_end;
		logic       strm_end;
	} enc_char_t;

	enc_char_t   char_q[$];      // characters owed by the block, oldest first
	logic [31:0] pend_word = '0; // bytes of the open group, big-endian
	logic [1:0]  pend_cnt = '0;  // bytes held in pend_word

	int unsigned error_count = 0;
	int unsigned char_count = 0;
	int unsigned stall_cycles = 0;

	// sender burst control
	bit          gaps_on = 1'b1;
	int unsigned burst_left = 0;

	// receiver stall pattern and long hold-off
	logic [15:0] pop_pat = 16'hFFFF;
	int unsigned pat_age = 0;
	int unsigned hold_req = 0;
	int unsigned hold_left = 0;

	ascii85_stream_encoder_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.empty      (empty),
		.pop        (pop),
		.out_char   (out_char),
		.group_end  (group_end),
		.stream_end (stream_end)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// one line per mismatch, printing capped so a broken block cannot flood the log
	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		error_count++;
		if (error_count <= 40) begin
			$display("mismatch at char %0d: %s got 0x%0h expected 0x%0h",
				char_count, what, got, want);
		end
	endtask

	// expected characters for one accepted byte; updates the open group
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		logic [31:0] w;
		logic [6:0]  digit[5];
		int unsigned nchars;
		enc_char_t   c;
		pend_word = pend_word | ({24'h0, b} << ((3 - int'(pend_cnt)) * 8));
		if (pend_cnt == 2'd3 || fin) begin
			// full group gives five digits, partial final group gives n+1
			nchars = (pend_cnt == 2'd3) ? 5 : int'(pend_cnt) + 2;
			if (pend_cnt == 2'd3 && pend_word == 32'h0) begin
				// all-zero full group collapses to one character, final or not
				c.ch       = ZERO_CHAR;
				c.grp_end  = 1'b1;
				c.strm_end = fin;
				char_q.push_back(c);
			end else begin
				// zero partial final group falls through here and gives '!' runs
				w = pend_word;
				for (int i = 4; i >= 0; i--) begin
					digit[i] = 7'(w % RADIX) + DIGIT_BASE;
					w = w / RADIX;
				end
				for (int i = 0; i < nchars; i++) begin
					c.ch       = digit[i];
					c.grp_end  = (i == nchars - 1);
					c.strm_end = (i == nchars - 1) && fin;
					char_q.push_back(c);
				end
			end
			pend_word = '0;
			pend_cnt  = '0;
		end else begin
			pend_cnt = pend_cnt + 2'd1;
		end
	endtask

	// offer one byte, wait for the request to be taken, then predict
	// called right after a rising edge; push stays high into the next call
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (gaps_on && burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left != 0) begin
			burst_left--;
		end
		push       <= 1'b1;
		data_byte  <= b;
		final_byte <= fin;
		do begin
			@(posedge clk);
		end while (full);
		encode_byte(b, fin);
	endtask

	// sender stops and waits until every owed character has been popped
	task automatic drain_pause();
		push <= 1'b0;
		@(posedge clk);
		while (char_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// extremes, zero groups, zero and nonzero partial final groups
	task automatic test_directed_groups();
		// max group, final on a full group
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		// zero full group mid stream, then zero full group as the last one
		repeat (4) send_byte(8'h00, 1'b0);
		repeat (3) send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		// zero partial final groups of one, two and three bytes
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		repeat (2) send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		// single max byte stream, then a three-byte mixed partial
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b1);
		drain_pause();
	endtask

	// receiver holds off while the sender keeps pushing full groups
	task automatic test_full_backpressure();
		gaps_on = 1'b0;
		hold_req = HOLD_OFF_CYCLES;
		for (int k = 0; k < 64; k++) begin
			send_byte(8'($urandom), k == 63);
		end
		gaps_on = 1'b1;
		drain_pause();
	endtask

	// well-formed streams with random content and length, some very short
	task automatic test_random_streams(input int unsigned n_bytes, input bit with_gaps);
		int unsigned sent;
		int unsigned len;
		int unsigned mode;
		logic [7:0]  b;
		sent = 0;
		mode = 0;
		gaps_on = with_gaps;
		while (sent < n_bytes) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 24);
			for (int k = 0; k < len; k++) begin
				// pick a flavor per group so zero and max groups show up often
				if (k % 4 == 0) begin
					mode = $urandom_range(0, 9);
				end
				case (mode)
					0: begin
						b = 8'h00;
					end
					1: begin
						b = 8'hFF;
					end
					default: begin
						b = 8'($urandom);
					end
				endcase
				send_byte(b, k == len - 1);
			end
			sent += len;
			if ($urandom_range(0, 15) == 0) begin
				drain_pause();
			end
		end
		gaps_on = 1'b1;
	endtask

	// receiver: check each popped character, then drive pop for the next edge
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (char_q.size() == 0) begin
				report_mismatch("character with no request behind it", out_char, 0);
			end else begin
				if (out_char !== char_q[0].ch) begin
					report_mismatch("out_char", out_char, char_q[0].ch);
				end
				if (group_end !== char_q[0].grp_end) begin
					report_mismatch("group_end", group_end, char_q[0].grp_end);
				end
				if (stream_end !== char_q[0].strm_end) begin
					report_mismatch("stream_end", stream_end, char_q[0].strm_end);
				end
				void'(char_q.pop_front());
			end
			char_count++;
		end
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			// long hold-off lets the job queue fill and push back on the input
			hold_left--;
			pop <= 1'b0;
		end else begin
			// rotating stall pattern, renewed now and then, sometimes no stalls at all
			if (pat_age == 0) begin
				pat_age = $urandom_range(32, 160);
				pop_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
				if (pop_pat == 16'h0000) begin
					pop_pat = 16'h0001;
				end
			end
			pat_age--;
			pop <= pop_pat[0];
			pop_pat = {pop_pat[0], pop_pat[15:1]};
		end
	end

	// watchdog: no request taken on either side for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request taken for %0d cycles", stall_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_groups();
		test_full_backpressure();
		test_random_streams(180, 1'b1);
		// a stretch without the sender's random burst gaps
		test_random_streams(60, 1'b0);

		// wait out every owed character, then give stray output time to show
		push <= 1'b0;
		@(posedge clk);
		while (char_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
